@@ src/fit_block_allocator_top_macros.svh @@
// assertion macros for the fit block allocator
// expects clk and rst in the scope of each use; no other dependencies
`ifndef FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define FBA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fit block allocator check failed");
// next-cycle implication, disabled during reset
`define FBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fit block allocator check failed");
`else
`define FBA_ASSERT_SAME(lbl, ante, cons)
`define FBA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/fba_pkg.sv @@
// shared constants and item types of the fit block allocator
// no dependencies
`default_nettype none

package fba_pkg;

  // table geometry
  localparam int NUM_BLOCKS   = 16;
  localparam int SIZE_WIDTH   = 16;
  localparam int MAX_REQUESTS = 32;
  localparam int BLK_W        = $clog2(NUM_BLOCKS);
  localparam int CNT_W        = $clog2(NUM_BLOCKS + 1);
  localparam int SEQ_W        = $clog2(MAX_REQUESTS);

  // field widths of the items
  localparam int SLOT_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b1;

  // fit modes; the unused code behaves as first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // item operations
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic                op;
    logic [SLOT_W-1:0]   block_slot;
    logic [AMOUNT_W-1:0] amount;
  } cmd_item_t;

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   block_number;
    logic [AMOUNT_W-1:0] remaining;
    logic [SEQ_W-1:0]    request_number;
  } rsp_item_t;

endpackage

`default_nettype wire

@@ src/fba_if.sv @@
// valid/ready channels carrying command and response items
// depends on fba_pkg
`default_nettype none

interface fba_cmd_if;
  import fba_pkg::*;

  logic      valid;
  logic      ready;
  cmd_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface fba_rsp_if;
  import fba_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ src/fba_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module fba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/fit_block_allocator_top.sv @@
// fit block allocator: free-size table with first, best and worst fit search
// depends on fba_pkg, fba_if, fba_ram and fit_block_allocator_top_macros.svh
// usage
//   cmd carries items: a load writes amount as the free size of block_slot,
//   a request asks for amount and is granted a block from the first
//   blocks_in_use entries (capped at 16) by the rule in fit_mode.
//   rsp returns one item per command: the chosen or written block, the size
//   left in it, and for requests the grant flag and a 5-bit sequence number.
//   cfg_we/cfg_index/cfg_data write fit_mode (index 0) or blocks_in_use
//   (index 1); write only while no command is in flight.
// sequencing
//   a load is written to the table and the response register from S_LOAD; a
//   request passes through S_SCAN and then S_WRITE: the table ram is read
//   one entry a cycle into the single fit comparator, then one subtract
//   writes the chosen block back. cmd.ready is high only while the sequencer
//   is idle, so a new command waits until the last one is through.
// reset and stalls
//   rst (synchronous) sets first fit, 16 blocks and sequence number zero;
//   the table holds no data until loaded. A command may be accepted while a
//   response waits; its own response then waits until rsp is taken.
`default_nettype none

`include "fit_block_allocator_top_macros.svh"

module fit_block_allocator_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fba_pkg::CFG_W-1:0]     cfg_data,
  fba_cmd_if.sink                            cmd,
  fba_rsp_if.source                          rsp
);
  import fba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOAD  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t                state;
  logic [1:0]            fit_mode;
  logic [CNT_W-1:0]      blocks_in_use;
  logic [SEQ_W-1:0]      request_count;
  cmd_item_t             cur;
  logic [CNT_W-1:0]      rd_idx;
  logic [BLK_W-1:0]      cmp_idx;
  logic                  cmp_valid;
  logic                  found;
  logic [BLK_W-1:0]      pick;
  logic [SIZE_WIDTH-1:0] best;
  logic                  rsp_valid;
  rsp_item_t             rsp_item;

  logic                  cmd_fire;
  logic                  rsp_free;
  logic [CNT_W-1:0]      limit;
  logic                  issue;
  logic                  fits;
  logic                  better;
  logic [SIZE_WIDTH-1:0] rdata;
  logic [SIZE_WIDTH-1:0] left;
  logic                  ram_we;
  logic [BLK_W-1:0]      ram_waddr;
  logic [SIZE_WIDTH-1:0] ram_wdata;

  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.item  = rsp_item;

  // entries searched, saturated to the table size
  assign limit = (blocks_in_use > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : blocks_in_use;
  assign issue = (state == S_SCAN) && (rd_idx < limit);

  // shared fit comparator on the entry just read
  assign fits   = (rdata >= cur.amount[SIZE_WIDTH-1:0]);
  assign better = !found
               || ((fit_mode == FIT_BEST)  && (rdata < best))
               || ((fit_mode == FIT_WORST) && (rdata > best));

  // one subtract for the write-back of the chosen block
  assign left = best - cur.amount[SIZE_WIDTH-1:0];

  // table write port: a load or the grant write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pick;
    ram_wdata = left;
    if (state == S_LOAD) begin
      ram_we    = rsp_free;
      ram_waddr = cur.block_slot[BLK_W-1:0];
      ram_wdata = cur.amount[SIZE_WIDTH-1:0];
    end else if (state == S_WRITE) begin
      ram_we = rsp_free && found;
    end
  end

  fba_ram #(
    .WIDTH (SIZE_WIDTH),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[BLK_W-1:0]),
    .rdata (rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= FIT_FIRST;
      blocks_in_use <= CNT_W'(NUM_BLOCKS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIT_MODE:      fit_mode      <= cfg_data[1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      request_count <= '0;
      rsp_valid     <= 1'b0;
      cmp_valid     <= 1'b0;
      found         <= 1'b0;
    end else begin
      // response flag: set when an item completes, cleared once taken
      if (((state == S_LOAD) || (state == S_WRITE)) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            state     <= (cmd.item.op == OP_REQUEST) ? S_SCAN : S_LOAD;
            found     <= 1'b0;
            cmp_valid <= 1'b0;
          end
        end
        S_LOAD: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          cmp_valid <= issue;
          if (cmp_valid && fits && better) begin
            found <= 1'b1;
          end
          if (!issue && !cmp_valid) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (rsp_free) begin
            request_count <= request_count + SEQ_W'(1);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      cur    <= cmd.item;
      rd_idx <= '0;
    end
    if (issue) begin
      rd_idx  <= rd_idx + CNT_W'(1);
      cmp_idx <= rd_idx[BLK_W-1:0];
    end
    if ((state == S_SCAN) && cmp_valid && fits && better) begin
      pick <= cmp_idx;
      best <= rdata;
    end
    // response register
    if ((state == S_LOAD) && rsp_free) begin
      rsp_item.granted        <= 1'b0;
      rsp_item.block_number   <= cur.block_slot;
      rsp_item.remaining      <= AMOUNT_W'(cur.amount[SIZE_WIDTH-1:0]);
      rsp_item.request_number <= '0;
    end else if ((state == S_WRITE) && rsp_free) begin
      rsp_item.granted        <= found;
      rsp_item.block_number   <= found ? SLOT_W'(pick) : '0;
      rsp_item.remaining      <= found ? AMOUNT_W'(left) : '0;
      rsp_item.request_number <= request_count;
    end
  end

  // checks
  `FBA_ASSERT_SAME(a_pick_in_range, (state == S_WRITE) && found, CNT_W'(pick) < limit)
  `FBA_ASSERT_SAME(a_scan_bounded, state == S_SCAN, rd_idx <= limit)
  `FBA_ASSERT_NEXT(a_request_scans, cmd_fire && (cmd.item.op == OP_REQUEST), state == S_SCAN)
  `FBA_ASSERT_NEXT(a_seq_advances, (state == S_WRITE) && rsp_free,
                   rsp_valid && (request_count == $past(request_count) + SEQ_W'(1)))

endmodule

`default_nettype wire
